>>> design/bbrt_pkg.sv
// ----------------------------------------------------------------------------
// bbrt_pkg
// Shared types, constants and microcode for the bad-block remap table.
// ----------------------------------------------------------------------------
`default_nettype none

package bbrt_pkg;

  localparam int BLOCK_BITS    = 14;
  localparam int SLOT_W        = 5;
  localparam int OP_W          = 3;
  localparam int NUM_SLOTS_DEF = 20;

  localparam logic [BLOCK_BITS-1:0] RESERVED_BASE_RST = BLOCK_BITS'(2048 - 40);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_FIND  = 3'd2,
    OP_BUILD = 3'd3,
    OP_XLATE = 3'd4
  } op_e;

  // input transaction payload, last field in the low bits
  typedef struct packed {
    logic [BLOCK_BITS-1:0] block_address;
    logic                  new_used;
    logic                  new_broken;
    logic [SLOT_W-1:0]     slot_index;
  } req_t;

  // result transaction payload, last field in the low bits
  typedef struct packed {
    logic                  remapped;
    logic [BLOCK_BITS-1:0] translated_address;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_slot;
    logic [BLOCK_BITS-1:0] read_block;
    logic                  read_used;
    logic                  read_broken;
  } res_t;

  localparam int REQ_W       = $bits(req_t);
  localparam int RES_W       = $bits(res_t);
  localparam int IN_TDATA_W  = ((REQ_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // slot table entry
  typedef struct packed {
    logic                  broken;
    logic                  used;
    logic [BLOCK_BITS-1:0] block;
  } slot_ent_t;

  // ---- microcode ----
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_FETCH = 4'd0;
  localparam upc_t UA_DONE  = 4'd1;
  localparam upc_t UA_WR0   = 4'd2;
  localparam upc_t UA_RD0   = 4'd3;
  localparam upc_t UA_RD1   = 4'd4;
  localparam upc_t UA_FND0  = 4'd5;
  localparam upc_t UA_FND1  = 4'd6;
  localparam upc_t UA_BLD0  = 4'd7;
  localparam upc_t UA_BLD1  = 4'd8;
  localparam upc_t UA_XL0   = 4'd9;
  localparam upc_t UA_XL1   = 4'd10;
  localparam upc_t UA_BAD   = 4'd11;

  typedef enum logic {
    SRC_INPUT,
    SRC_COUNT
  } src_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_READ_CAP,
    ACT_FREE_CHK,
    ACT_MAP_CLR,
    ACT_MAP_ADD,
    ACT_XLATE_INIT,
    ACT_XLATE_CHK
  } act_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_RETIRE,
    C_MAP_EMPTY,
    C_HIT_OR_SLOT_LAST,
    C_SLOT_LAST,
    C_HIT_OR_MAP_LAST
  } cond_e;

  typedef struct packed {
    logic  slot_rd;
    src_e  slot_src;
    logic  slot_wr;
    logic  map_rd;
    logic  cnt_inc;
    act_e  act;
    cond_e cond;
    logic  hold;    // stay on this step when the branch is not taken
    upc_t  target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic hit;
    logic slot_last;
    logic map_last;
    logic map_empty;
    op_e  opcode;
  } stat_t;

  function automatic upc_t dispatch(input op_e op);
    upc_t a;
    case (op)
      OP_WRITE: a = UA_WR0;
      OP_READ:  a = UA_RD0;
      OP_FIND:  a = UA_FND0;
      OP_BUILD: a = UA_BLD0;
      OP_XLATE: a = UA_XL0;
      default:  a = UA_BAD;
    endcase
    return a;
  endfunction

  function automatic uword_t ucode_rom(input upc_t upc);
    uword_t w;
    w          = '0;
    w.slot_src = SRC_COUNT;
    w.act      = ACT_NONE;
    w.cond     = C_JUMP;
    w.target   = UA_DONE;
    case (upc)
      UA_FETCH: begin
        w.cond = C_DISPATCH; w.hold = 1'b1;
      end
      UA_DONE: begin
        w.cond = C_RETIRE; w.hold = 1'b1; w.target = UA_FETCH;
      end
      UA_WR0: begin
        w.slot_wr = 1'b1;
      end
      UA_RD0: begin
        w.slot_rd = 1'b1; w.slot_src = SRC_INPUT; w.cond = C_NEXT;
      end
      UA_RD1: begin
        w.act = ACT_READ_CAP;
      end
      UA_FND0: begin
        w.slot_rd = 1'b1; w.cnt_inc = 1'b1; w.cond = C_NEXT;
      end
      UA_FND1: begin
        w.slot_rd = 1'b1; w.cnt_inc = 1'b1; w.act = ACT_FREE_CHK;
        w.cond = C_HIT_OR_SLOT_LAST; w.hold = 1'b1;
      end
      UA_BLD0: begin
        w.slot_rd = 1'b1; w.cnt_inc = 1'b1; w.act = ACT_MAP_CLR; w.cond = C_NEXT;
      end
      UA_BLD1: begin
        w.slot_rd = 1'b1; w.cnt_inc = 1'b1; w.act = ACT_MAP_ADD;
        w.cond = C_SLOT_LAST; w.hold = 1'b1;
      end
      UA_XL0: begin
        w.map_rd = 1'b1; w.cnt_inc = 1'b1; w.act = ACT_XLATE_INIT;
        w.cond = C_MAP_EMPTY;
      end
      UA_XL1: begin
        w.map_rd = 1'b1; w.cnt_inc = 1'b1; w.act = ACT_XLATE_CHK;
        w.cond = C_HIT_OR_MAP_LAST; w.hold = 1'b1;
      end
      UA_BAD: begin
        w.cond = C_JUMP;
      end
      default: begin
        w.cond = C_JUMP; w.target = UA_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/bad_block_remap_table_core.sv
// ----------------------------------------------------------------------------
// bad_block_remap_table_core
// Flash bad-block remap table: spare slots, free-slot search, snapshot map
// rebuild and address translation, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Find stops at the first free slot and rebuild walks every slot; address
// translation stops at the first map hit or last entry, and skips an empty map.
// Scans are bound by the one read port of the slot RAM / map RAM: one entry
// per cycle. One transaction in flight; the next is accepted in the cycle
// after the result moves to the output register, even if it is not taken.
// Reset: async, active low; clears slot valid bits (slots read as zero),
// map count, sequencer and output valid; reserved_base returns to 2008.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_block_remap_table_core
  import bbrt_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // config: reserved_base
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [BLOCK_BITS-1:0]  cfg_data_i,
  // request stream
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // tdata: slot_index[4:0], new_broken[5], new_used[6], block_address[20:7]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: opcode[2:0]
  input  wire logic [OP_W-1:0]        s_axis_tuser_i,
  // result stream
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // tdata: read_broken[0], read_used[1], read_block[15:2], free_slot[20:16],
  //        free_found[21], translated_address[35:22], remapped[36]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int ENT_W = $bits(slot_ent_t);
  localparam int MAP_W = IDX_W + BLOCK_BITS;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  uword_t uw;
  stat_t  stat;

  bbrt_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .uword_o (uw)
  );

  // ---------------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------------
  logic [BLOCK_BITS-1:0] base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= RESERVED_BASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Request latch and handshakes
  // ---------------------------------------------------------------------------
  logic  in_fire, out_free, retire;
  req_t  req_q;

  assign s_axis_tready_o = (uw.cond == C_DISPATCH);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_t'(s_axis_tdata_i[REQ_W-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Scan counter, tracks the entry addressed by the next scan read
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cnt_ok;

  assign cnt_ok = cnt_q < CNT_W'(NUM_SLOTS);

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      cnt_d = '0;
    end else if (uw.cnt_inc && cnt_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot table: RAM plus per-entry valid bits (invalid entries read as zero)
  // ---------------------------------------------------------------------------
  logic                 slot_in_range;
  logic                 slot_we, slot_re;
  logic [IDX_W-1:0]     slot_raddr;
  logic [ENT_W-1:0]     slot_rdata;
  logic [NUM_SLOTS-1:0] slot_vld_q;
  logic                 rd_vld_q;
  logic                 rd_ok_q;
  logic [IDX_W-1:0]     rd_idx_q;
  slot_ent_t            wr_ent;
  slot_ent_t            sd;

  assign slot_in_range = (SLOT_W + 1)'(req_q.slot_index) < (SLOT_W + 1)'(NUM_SLOTS);
  assign slot_we       = uw.slot_wr && slot_in_range;
  assign slot_raddr    = (uw.slot_src == SRC_INPUT) ? req_q.slot_index[IDX_W-1:0]
                                                    : cnt_q[IDX_W-1:0];
  assign slot_re       = uw.slot_rd && ((uw.slot_src == SRC_INPUT) ? slot_in_range : cnt_ok);

  assign wr_ent.broken = req_q.new_broken;
  assign wr_ent.used   = req_q.new_used;
  assign wr_ent.block  = req_q.block_address;

  bbrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (req_q.slot_index[IDX_W-1:0]),
    .wdata_i (wr_ent),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (slot_we) begin
      slot_vld_q[req_q.slot_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_re) begin
      rd_vld_q <= slot_vld_q[slot_raddr];
    end
  end

  assign sd = rd_vld_q ? slot_ent_t'(slot_rdata) : '0;

  // rd_ok_q: a direct slot read was in range; rd_idx_q: entry of last scan read
  logic map_re;

  always_ff @(posedge clk_i) begin
    if (uw.slot_rd && uw.slot_src == SRC_INPUT) begin
      rd_ok_q <= slot_in_range;
    end
    if (slot_re && uw.slot_src == SRC_COUNT || map_re) begin
      rd_idx_q <= cnt_q[IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Snapshot map: {slot, logical block} per entry, filled in slot order
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]      map_count_q, map_count_d;
  logic                  map_we;
  logic [MAP_W-1:0]      map_rdata;
  logic [IDX_W-1:0]      map_slot;
  logic [BLOCK_BITS-1:0] map_block;

  assign map_re = uw.map_rd && cnt_ok;

  bbrt_ram #(
    .WIDTH (MAP_W),
    .DEPTH (NUM_SLOTS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_count_q[IDX_W-1:0]),
    .wdata_i ({rd_idx_q, sd.block}),
    .re_i    (map_re),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (map_rdata)
  );

  assign map_slot  = map_rdata[MAP_W-1:BLOCK_BITS];
  assign map_block = map_rdata[BLOCK_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Datapath actions
  // ---------------------------------------------------------------------------
  res_t res_q, res_d;
  logic hit;

  always_comb begin
    hit         = 1'b0;
    map_we      = 1'b0;
    map_count_d = map_count_q;
    res_d       = res_q;
    if (in_fire) begin
      res_d = '0;
    end
    case (uw.act)
      ACT_READ_CAP: begin
        if (rd_ok_q) begin
          res_d.read_broken = sd.broken;
          res_d.read_used   = sd.used;
          res_d.read_block  = sd.block;
        end
      end
      ACT_FREE_CHK: begin
        hit = !sd.broken && !sd.used;
        if (hit) begin
          res_d.free_slot  = SLOT_W'(rd_idx_q);
          res_d.free_found = 1'b1;
        end
      end
      ACT_MAP_CLR: begin
        map_count_d = '0;
      end
      ACT_MAP_ADD: begin
        map_we = sd.used && !sd.broken;
        if (map_we) begin
          map_count_d = map_count_q + CNT_W'(1);
        end
      end
      ACT_XLATE_INIT: begin
        res_d.translated_address = req_q.block_address;
      end
      ACT_XLATE_CHK: begin
        hit = (map_block == req_q.block_address);
        if (hit) begin
          res_d.translated_address = base_q + BLOCK_BITS'(map_slot);
          res_d.remapped           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_count_q <= '0;
    end else begin
      map_count_q <= map_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer status
  // ---------------------------------------------------------------------------
  assign stat.in_fire   = in_fire;
  assign stat.out_free  = out_free;
  assign stat.hit       = hit;
  assign stat.slot_last = (rd_idx_q == IDX_W'(NUM_SLOTS - 1));
  assign stat.map_last  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == map_count_q);
  assign stat.map_empty = (map_count_q == '0);
  assign stat.opcode    = op_e'(s_axis_tuser_i);

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_valid_d;
  res_t out_q;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign retire   = (uw.cond == C_RETIRE) && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (retire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_from_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(uw.cond == C_RETIRE))
    else $error("result appeared without a retire step");

  a_leave_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (uw.cond != C_DISPATCH))
    else $error("sequencer stayed in fetch after an accepted transaction");

  a_map_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_count_q <= CNT_W'(NUM_SLOTS))
    else $error("map count exceeds slot count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_SLOTS))
    else $error("scan counter past end of table");

endmodule

`default_nettype wire

>>> design/bbrt_ram.sv
// ----------------------------------------------------------------------------
// bbrt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bbrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/bbrt_useq.sv
// ----------------------------------------------------------------------------
// bbrt_useq
// Microprogram sequencer: step counter, control ROM, branch logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bbrt_useq
  import bbrt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire stat_t  stat_i,
  output uword_t      uword_o
);

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   take;
  upc_t   tgt;

  assign uw = ucode_rom(upc_q);

  always_comb begin
    tgt = uw.target;
    case (uw.cond)
      C_NEXT:             take = 1'b0;
      C_JUMP:             take = 1'b1;
      C_DISPATCH: begin
        take = stat_i.in_fire;
        tgt  = dispatch(stat_i.opcode);
      end
      C_RETIRE:           take = stat_i.out_free;
      C_MAP_EMPTY:        take = stat_i.map_empty;
      C_HIT_OR_SLOT_LAST: take = stat_i.hit | stat_i.slot_last;
      C_SLOT_LAST:        take = stat_i.slot_last;
      C_HIT_OR_MAP_LAST:  take = stat_i.hit | stat_i.map_last;
      default:            take = 1'b1;
    endcase
    if (take) begin
      upc_d = tgt;
    end else if (uw.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign uword_o = uw;

endmodule

`default_nettype wire
